### rtl/cits_pkg.sv
// Package: types, codes and constants of the chunked image transfer sender.
`timescale 1ns / 1ps
package cits_pkg;

  localparam logic [2:0] OP_PHOTO   = 3'd0;
  localparam logic [2:0] OP_REQ     = 3'd1;
  localparam logic [2:0] OP_BACK    = 3'd2;
  localparam logic [2:0] OP_CACK    = 3'd3;
  localparam logic [2:0] OP_SPI     = 3'd4;
  localparam logic [2:0] OP_RES     = 3'd5;
  localparam logic [2:0] OP_TICK    = 3'd6;
  localparam logic [2:0] OP_UNKNOWN = 3'd7;

  localparam logic [2:0] MK_NONE  = 3'd0;
  localparam logic [2:0] MK_BEGIN = 3'd1;
  localparam logic [2:0] MK_READY = 3'd2;
  localparam logic [2:0] MK_SPI   = 3'd3;
  localparam logic [2:0] MK_END   = 3'd4;
  localparam logic [2:0] MK_ABORT = 3'd5;
  localparam logic [2:0] MK_OK    = 3'd6;
  localparam logic [2:0] MK_FAIL  = 3'd7;

  localparam logic [3:0] AR_NONE      = 4'd0;
  localparam logic [3:0] AR_SHORT_BEG = 4'd1;
  localparam logic [3:0] AR_REJECTED  = 4'd2;
  localparam logic [3:0] AR_SHORT_CHK = 4'd3;
  localparam logic [3:0] AR_NAK       = 4'd4;
  localparam logic [3:0] AR_ACK_IDX   = 4'd5;
  localparam logic [3:0] AR_RANGE     = 4'd6;
  localparam logic [3:0] AR_SPI_FAIL  = 4'd7;
  localparam logic [3:0] AR_SPI_IDX   = 4'd8;
  localparam logic [3:0] AR_TIMEOUT   = 4'd9;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_BEGIN  = 3'd1;
  localparam logic [2:0] ST_CHUNK  = 3'd2;
  localparam logic [2:0] ST_SPI    = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  localparam logic [2:0] REG_DEFAULT  = 3'd0;
  localparam logic [2:0] REG_MAX      = 3'd1;
  localparam logic [2:0] REG_TIMEOUT  = 3'd2;
  localparam logic [2:0] REG_OWN      = 3'd3;
  localparam logic [2:0] REG_FALLBACK = 3'd4;

  localparam logic [3:0] BEGIN_MIN_LEN = 4'd4;
  localparam logic [3:0] ACK_MIN_LEN   = 4'd5;
  localparam logic [7:0] MISSING_STATUS = 8'hFF;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  sender_node;
    logic [3:0]  payload_len;
    logic [7:0]  status_code;
    logic [15:0] chunk_index;
    logic [15:0] offered_chunk;
    logic [7:0]  session_id;
    logic [31:0] photo_id;
    logic [31:0] file_bytes;
    logic [31:0] file_crc;
    logic        file_ok;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  msg_kind;
    logic [7:0]  receiver_node;
    logic [31:0] xfer_image_id;
    logic [31:0] total_bytes;
    logic [15:0] chunk_bytes;
    logic [31:0] image_crc;
    logic [15:0] out_chunk_index;
    logic [31:0] byte_offset;
    logic [15:0] byte_len;
    logic [3:0]  abort_reason;
    logic [7:0]  ok_count;
    logic [7:0]  err_count;
  } out_item_t;

  // Request to and answer from the shared divider.
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

endpackage

### rtl/cits_div.sv
// Shared restoring divider: one quotient bit per cycle, ceiling of a/b.
`timescale 1ns / 1ps
module cits_div (
  input  logic              clk,
  input  logic              rst,
  input  cits_pkg::div_req_t req,
  output cits_pkg::div_rsp_t rsp
);

  logic [5:0]  count;
  logic        busy;
  logic        done;
  logic [32:0] num;
  logic [16:0] rem;
  logic [15:0] dvs;
  logic [32:0] quo;
  logic [17:0] trial;

  // Ceiling: divide (a + b - 1) by b; the numerator needs 33 bits.
  assign trial = {rem, num[32]} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= 6'd33;
        num   <= {1'b0, req.dividend} + {17'd0, req.divisor} - 33'd1;
        dvs   <= req.divisor;
        rem   <= '0;
        quo   <= '0;
      end else if (busy) begin
        if (!trial[17]) begin
          rem <= trial[16:0];
          quo <= {quo[31:0], 1'b1};
        end else begin
          rem <= {rem[15:0], num[32]};
          quo <= {quo[31:0], 1'b0};
        end
        num   <= {num[31:0], 1'b0};
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo[31:0];

endmodule

### rtl/chunked_image_transfer_sender_top.sv
// Top level of the chunked image transfer sender.
`timescale 1ns / 1ps
// Channel | Signals                          | Direction
// input   | in_valid, in_ready, in_data      | events into the block
// output  | out_valid, out_ready, out_data   | one result per event
// config  | cfg_we, cfg_index, cfg_data      | register writes, no wait
//
// Every event gives exactly one result transfer. Most events go from the accept
// through one execute state straight to offering the result. An accepted request
// or a usable chunk size offer runs the shared bit-serial divider for the chunk
// count: 33 steps while waiting in SQ_DIV. A chunk ack multiplies chunk index by
// chunk size and checks the range in a further state, SQ_MUL. Reset is synchronous;
// it resets registers and transfer state, not the held event, result or operands.
// The block takes no new event while a result waits for out_ready.
module chunked_image_transfer_sender_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  cits_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output cits_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  localparam logic [2:0] SQ_IDLE = 3'd0;
  localparam logic [2:0] SQ_EXEC = 3'd1;
  localparam logic [2:0] SQ_DIV  = 3'd2;
  localparam logic [2:0] SQ_MUL  = 3'd3;
  localparam logic [2:0] SQ_OUT  = 3'd4;

  logic [15:0] r_default, r_max, r_timeout;
  logic [7:0]  r_own, r_fallback;

  logic [2:0]  seq;
  cits_pkg::in_item_t ev;
  cits_pkg::out_item_t res;

  logic [2:0]  xfer_state;
  logic        photo_available;
  logic [31:0] last_photo_id, cur_image_id, cur_total_bytes, cur_crc;
  logic [31:0] total_chunk_count, next_chunk;
  logic [15:0] cur_chunk_bytes, stuck_ticks;
  logic [7:0]  peer_node, session_byte, good_transfers, bad_transfers;
  logic [47:0] product;

  cits_pkg::div_req_t dreq;
  cits_pkg::div_rsp_t drsp;

  cits_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic [15:0] clamp;
  logic [16:0] stuck_inc;
  logic        offer_ok;
  logic [32:0] remain;
  logic [31:0] next_inc;

  always_comb begin
    clamp = (r_default > r_max) ? r_max : r_default;
    if (clamp == 16'd0) clamp = 16'd1;
    offer_ok  = (ev.offered_chunk != 16'd0) && (ev.offered_chunk <= r_max);
    stuck_inc = {1'b0, stuck_ticks} + 17'd1;
    remain    = {1'b0, cur_total_bytes} - product[32:0];
    next_inc  = next_chunk + 32'd1;
  end

  assign in_ready  = (seq == SQ_IDLE);
  assign out_valid = (seq == SQ_OUT);

  // Counters are shown as they stand after the event; they only move while
  // the event executes, so the live registers are right while the result waits.
  always_comb begin
    out_data           = res;
    out_data.ok_count  = good_transfers;
    out_data.err_count = bad_transfers;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_default  <= 16'd256;
      r_max      <= 16'd256;
      r_timeout  <= 16'd10;
      r_own      <= 8'd0;
      r_fallback <= 8'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cits_pkg::REG_DEFAULT:  r_default  <= cfg_data;
        cits_pkg::REG_MAX:      r_max      <= cfg_data;
        cits_pkg::REG_TIMEOUT:  r_timeout  <= cfg_data;
        cits_pkg::REG_OWN:      r_own      <= cfg_data[7:0];
        cits_pkg::REG_FALLBACK: r_fallback <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= SQ_IDLE;
      xfer_state <= cits_pkg::ST_IDLE;
      photo_available <= 1'b0;
      last_photo_id <= '0; peer_node <= '0; cur_image_id <= '0;
      cur_total_bytes <= '0; cur_crc <= '0; cur_chunk_bytes <= '0;
      total_chunk_count <= '0; next_chunk <= '0; stuck_ticks <= '0;
      session_byte <= '0; good_transfers <= '0; bad_transfers <= '0;
      dreq.start <= 1'b0;
    end else begin
      unique case (seq)
        SQ_IDLE: begin
          if (in_valid) begin
            ev  <= in_data;
            res <= '0;
            seq <= SQ_EXEC;
          end
        end
        SQ_EXEC: begin
          seq <= SQ_OUT;
          unique case (ev.op)
            cits_pkg::OP_PHOTO: begin
              if (ev.file_ok) begin
                last_photo_id <= ev.photo_id;
                photo_available <= 1'b1;
              end
            end
            cits_pkg::OP_REQ: begin
              if (xfer_state == cits_pkg::ST_IDLE && photo_available && ev.file_ok &&
                  ev.file_bytes != 32'd0) begin
                peer_node       <= (ev.sender_node != r_own) ? ev.sender_node : r_fallback;
                cur_image_id    <= last_photo_id;
                cur_total_bytes <= ev.file_bytes;
                cur_crc         <= ev.file_crc;
                cur_chunk_bytes <= clamp;
                next_chunk      <= '0;
                stuck_ticks     <= '0;
                xfer_state      <= cits_pkg::ST_BEGIN;
                dreq.start      <= 1'b1;
                dreq.dividend   <= ev.file_bytes;
                dreq.divisor    <= clamp;
                seq             <= SQ_DIV;
                res.msg_kind    <= cits_pkg::MK_BEGIN;
                res.receiver_node <= (ev.sender_node != r_own) ? ev.sender_node : r_fallback;
                res.xfer_image_id <= last_photo_id;
                res.total_bytes <= ev.file_bytes;
                res.chunk_bytes <= clamp;
                res.image_crc   <= ev.file_crc;
              end
            end
            cits_pkg::OP_BACK: begin
              if (xfer_state == cits_pkg::ST_BEGIN) begin
                res.receiver_node <= peer_node;
                if (ev.payload_len < cits_pkg::BEGIN_MIN_LEN) begin
                  xfer_state <= cits_pkg::ST_IDLE;
                  bad_transfers <= bad_transfers + 8'd1;
                  res.msg_kind <= cits_pkg::MK_ABORT;
                  res.abort_reason <= cits_pkg::AR_SHORT_BEG;
                end else begin
                  session_byte <= ev.session_id;
                  if (ev.status_code != 8'd0) begin
                    xfer_state <= cits_pkg::ST_IDLE;
                    bad_transfers <= bad_transfers + 8'd1;
                    res.msg_kind <= cits_pkg::MK_ABORT;
                    res.abort_reason <= cits_pkg::AR_REJECTED;
                  end else begin
                    next_chunk  <= '0;
                    stuck_ticks <= '0;
                    xfer_state  <= cits_pkg::ST_CHUNK;
                    res.msg_kind <= cits_pkg::MK_READY;
                    res.chunk_bytes <= offer_ok ? ev.offered_chunk : cur_chunk_bytes;
                    if (offer_ok) begin
                      cur_chunk_bytes <= ev.offered_chunk;
                      dreq.start    <= 1'b1;
                      dreq.dividend <= cur_total_bytes;
                      dreq.divisor  <= ev.offered_chunk;
                      seq           <= SQ_DIV;
                    end
                  end
                end
              end
            end
            cits_pkg::OP_CACK: begin
              if (xfer_state == cits_pkg::ST_CHUNK) begin
                res.receiver_node <= peer_node;
                if (ev.payload_len < cits_pkg::ACK_MIN_LEN) begin
                  xfer_state <= cits_pkg::ST_IDLE;
                  bad_transfers <= bad_transfers + 8'd1;
                  res.msg_kind <= cits_pkg::MK_ABORT;
                  res.abort_reason <= cits_pkg::AR_SHORT_CHK;
                end else if (ev.status_code != 8'd0) begin
                  xfer_state <= cits_pkg::ST_IDLE;
                  bad_transfers <= bad_transfers + 8'd1;
                  res.msg_kind <= cits_pkg::MK_ABORT;
                  res.abort_reason <= cits_pkg::AR_NAK;
                end else if (ev.chunk_index != next_chunk[15:0]) begin
                  xfer_state <= cits_pkg::ST_IDLE;
                  bad_transfers <= bad_transfers + 8'd1;
                  res.msg_kind <= cits_pkg::MK_ABORT;
                  res.abort_reason <= cits_pkg::AR_ACK_IDX;
                end else begin
                  // A 32 by 16 bit product; the range check follows in the SQ_MUL state.
                  product <= {16'd0, next_chunk} * {32'd0, cur_chunk_bytes};
                  seq <= SQ_MUL;
                end
              end
            end
            cits_pkg::OP_SPI: begin
              if (xfer_state == cits_pkg::ST_SPI) begin
                res.receiver_node <= peer_node;
                if (ev.status_code != 8'd0) begin
                  xfer_state <= cits_pkg::ST_IDLE;
                  bad_transfers <= bad_transfers + 8'd1;
                  res.msg_kind <= cits_pkg::MK_ABORT;
                  res.abort_reason <= cits_pkg::AR_SPI_FAIL;
                end else if (ev.chunk_index != next_chunk[15:0]) begin
                  xfer_state <= cits_pkg::ST_IDLE;
                  bad_transfers <= bad_transfers + 8'd1;
                  res.msg_kind <= cits_pkg::MK_ABORT;
                  res.abort_reason <= cits_pkg::AR_SPI_IDX;
                end else begin
                  next_chunk  <= next_inc;
                  stuck_ticks <= '0;
                  if (next_inc < total_chunk_count) begin
                    xfer_state <= cits_pkg::ST_CHUNK;
                    res.msg_kind <= cits_pkg::MK_READY;
                    res.chunk_bytes <= cur_chunk_bytes;
                    res.out_chunk_index <= next_inc[15:0];
                  end else begin
                    xfer_state <= cits_pkg::ST_RESULT;
                    res.msg_kind <= cits_pkg::MK_END;
                  end
                end
              end
            end
            cits_pkg::OP_RES: begin
              if (xfer_state == cits_pkg::ST_RESULT) begin
                xfer_state <= cits_pkg::ST_IDLE;
                if (ev.payload_len != 4'd0 && ev.status_code == 8'd0) begin
                  good_transfers <= good_transfers + 8'd1;
                  res.msg_kind <= cits_pkg::MK_OK;
                end else begin
                  bad_transfers <= bad_transfers + 8'd1;
                  res.msg_kind <= cits_pkg::MK_FAIL;
                end
              end
            end
            cits_pkg::OP_TICK: begin
              if (xfer_state != cits_pkg::ST_IDLE) begin
                stuck_ticks <= stuck_inc[15:0];
                if (stuck_inc[15:0] >= r_timeout) begin
                  xfer_state <= cits_pkg::ST_IDLE;
                  bad_transfers <= bad_transfers + 8'd1;
                  res.msg_kind <= cits_pkg::MK_ABORT;
                  res.receiver_node <= peer_node;
                  res.abort_reason <= cits_pkg::AR_TIMEOUT;
                end
              end
            end
            default: ;
          endcase
        end
        SQ_DIV: begin
          // Wait for the divider; the start pulse lands in the first cycle here.
          dreq.start <= 1'b0;
          if (drsp.done) begin
            total_chunk_count <= drsp.quotient;
            seq <= SQ_OUT;
          end
        end
        SQ_MUL: begin
          seq <= SQ_OUT;
          if (product[47:32] != 16'd0 || product[31:0] >= cur_total_bytes) begin
            xfer_state <= cits_pkg::ST_IDLE;
            bad_transfers <= bad_transfers + 8'd1;
            res.msg_kind <= cits_pkg::MK_ABORT;
            res.abort_reason <= cits_pkg::AR_RANGE;
          end else begin
            stuck_ticks <= '0;
            xfer_state <= cits_pkg::ST_SPI;
            res.msg_kind <= cits_pkg::MK_SPI;
            res.chunk_bytes <= cur_chunk_bytes;
            res.out_chunk_index <= next_chunk[15:0];
            res.byte_offset <= product[31:0];
            res.byte_len <= (remain < {17'd0, cur_chunk_bytes}) ? remain[15:0]
                                                               : cur_chunk_bytes;
          end
        end
        SQ_OUT: begin
          if (out_ready) seq <= SQ_IDLE;
        end
        default: seq <= SQ_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_out: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_div_seq: assert property (@(posedge clk) disable iff (rst)
    drsp.done |-> seq == SQ_DIV) else $error("divider finished outside wait");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
`endif

endmodule
